/* src/tpc_pkg.sv */
// Shared constants and widths for the three-point curvature block.
package tpc_pkg;

    localparam int POINTS   = 128;
    localparam int ADDR_W   = $clog2(POINTS);
    localparam int COORD_W  = 8;
    localparam int PT_W     = 2 * COORD_W;
    localparam int INDEX_W  = 7;
    localparam int SPACE_W  = 6;
    localparam int LAST_W   = 8;
    localparam int DELTA_W  = COORD_W + 1;
    localparam int CROSS_W  = 2 * DELTA_W;
    localparam int D2_W     = 2 * COORD_W + 1;
    localparam int RAD_W    = D2_W + 16;
    localparam int SQ_W     = RAD_W + 1;
    localparam int ROOT_W   = 17;
    localparam int MAG_W    = 16;
    localparam int P1_W     = 2 * ROOT_W;
    localparam int PROD_W   = 51;
    localparam int REM_W    = PROD_W + 1;
    localparam int QUOT_W   = 19;
    localparam int CURV_W   = 18;

    localparam logic [CURV_W-1:0] CURV_MAX = 18'h1FFFF;
    localparam logic [CURV_W-1:0] CURV_MIN = 18'h20000;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

/* src/tpc_if.sv */
// Input and result channel interfaces.
interface tpc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [tpc_pkg::INDEX_W-1:0]   index;
    logic [tpc_pkg::COORD_W-1:0]   x;
    logic [tpc_pkg::COORD_W-1:0]   y;
    logic [tpc_pkg::SPACE_W-1:0]   spacing;

    modport source (output valid, mode, index, x, y, spacing, input ready);
    modport sink   (input valid, mode, index, x, y, spacing, output ready);
endinterface

interface tpc_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [tpc_pkg::CURV_W-1:0] curvature;
    logic                              out_of_range;

    modport source (output valid, curvature, out_of_range, input ready);
    modport sink   (input valid, curvature, out_of_range, output ready);
endinterface

/* src/tpc_ram.sv */
// Generic single-port RAM with registered read.
module tpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/tpc_sqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
module tpc_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tpc_pkg::D2_W-1:0]   i_d2,
    output logic                       o_done,
    output logic [tpc_pkg::ROOT_W-1:0] o_root
);
    import tpc_pkg::*;

    logic [SQ_W-1:0] r_rem, r_res, r_bit;
    logic [4:0]      r_cnt;
    logic            r_busy, r_done;
    logic [SQ_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= SQ_W'({i_d2, 16'd0});
                r_res  <= '0;
                r_bit  <= SQ_W'(1) << (RAD_W - 1);
                r_cnt  <= 5'(ROOT_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];
endmodule

/* src/tpc_div.sv */
// Restoring divider: (mag << 42) / den, 19 quotient bits plus overflow flag.
module tpc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tpc_pkg::MAG_W-1:0]  i_mag,
    input  logic [tpc_pkg::PROD_W-1:0] i_den,
    output logic                       o_done,
    output logic [tpc_pkg::QUOT_W-1:0] o_quot,
    output logic                       o_ovf
);
    import tpc_pkg::*;

    logic [REM_W-1:0]  r_rem, rem_sh;
    logic [PROD_W-1:0] r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [4:0]        r_cnt;
    logic              r_busy, r_done, r_ovf;
    logic [PROD_W-1:0] hi;

    // top part of the shifted numerator; quotient would not fit if it reaches den
    assign hi     = PROD_W'({i_mag, 23'd0});
    assign rem_sh = {r_rem[REM_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den  <= i_den;
                r_rem  <= REM_W'(hi);
                r_quot <= '0;
                r_cnt  <= 5'(QUOT_W - 1);
                r_ovf  <= (hi >= i_den);
                r_busy <= (hi < i_den);
                r_done <= (hi >= i_den);
            end else if (r_busy) begin
                if (rem_sh >= REM_W'(r_den)) begin
                    r_rem  <= rem_sh - REM_W'(r_den);
                    r_quot <= {r_quot[QUOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_quot <= {r_quot[QUOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;
endmodule

/* src/three_point_curvature.sv */
// Three-point curvature: a store of 128 (x,y) points, each 8 bits per coordinate,
// held in a single-port RAM. A write transaction (mode 0) stores a point and gives
// no result. A query transaction (mode 1) reads the points at index, index+spacing
// and index+2*spacing and returns the signed curvature 4*area / (|AB|*|BC|*|AC|)
// in Q2.16, sign giving the turn direction. Side lengths carry 8 fraction bits. A
// query whose last point lies past the store flags out_of_range with curvature 0
// and goes straight to the output register. Coincident points give 0 without the
// square roots or the divider. A full query runs through these steps in order:
// - three RAM reads, the delta stage and the squared-length stage;
// - three square roots of 17 iterations each run through one shared bit-serial
//   root unit;
// - two multiplier steps follow;
// - a 19-iteration restoring divider;
// - the output register.
// New transactions are taken only when the sequencer is idle. It goes idle in the
// same cycle as the result is registered. A finished result sits in the output
// register, so the next transaction is accepted while it waits to be taken. A
// result still held there stalls the following query's result and so holds off
// new transactions too.
// Reading a point that was never written gives an undefined result.
module three_point_curvature (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpc_in_if.sink      i_in,
    tpc_res_if.source   o_res
);
    import tpc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD_A  = 4'd1;
    localparam logic [3:0] ST_RD_B  = 4'd2;
    localparam logic [3:0] ST_RD_C  = 4'd3;
    localparam logic [3:0] ST_LD_C  = 4'd4;
    localparam logic [3:0] ST_CROSS = 4'd5;
    localparam logic [3:0] ST_DIST  = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_MUL1  = 4'd8;
    localparam logic [3:0] ST_MUL2  = 4'd9;
    localparam logic [3:0] ST_DIV   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0]               r_state;
    logic [ADDR_W-1:0]        r_ia, r_ib, r_ic;
    logic [COORD_W-1:0]       r_xa, r_ya, r_xb, r_yb, r_xc, r_yc;
    logic signed [DELTA_W-1:0] r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3;
    logic signed [CROSS_W-1:0] r_cross;
    logic [D2_W-1:0]          r_d2 [3];
    logic [ROOT_W-1:0]        r_root [3];
    logic [1:0]               r_side;
    logic [P1_W-1:0]          r_p1;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_sq_start, r_div_start;
    logic [CURV_W-1:0]        r_pend_curv;
    logic                     r_pend_oor;
    logic                     r_res_valid;
    logic [CURV_W-1:0]        r_res_curv;
    logic                     r_res_oor;

    // input side
    logic              in_acc;
    logic [LAST_W-1:0] q_mid, q_last;
    logic              q_oor;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [PT_W-1:0]   ram_rdata;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign q_mid      = LAST_W'(i_in.index) + LAST_W'(i_in.spacing);
    assign q_last     = q_mid + LAST_W'(i_in.spacing);
    assign q_oor      = (int'(q_last) >= POINTS);
    assign ram_we     = in_acc && (i_in.mode == MODE_WRITE) && (int'(i_in.index) < POINTS);

    always_comb begin
        unique case (r_state)
            ST_RD_A: ram_addr = r_ia;
            ST_RD_B: ram_addr = r_ib;
            ST_RD_C: ram_addr = r_ic;
            default: ram_addr = ADDR_W'(i_in.index);
        endcase
    end

    tpc_ram #(.WIDTH(PT_W), .DEPTH(POINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({i_in.y, i_in.x}),
        .o_rdata (ram_rdata)
    );

    // shared root unit, one side at a time
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;

    tpc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_d2    (r_d2[r_side]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    logic              div_done, div_ovf;
    logic [QUOT_W-1:0] div_quot;

    tpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_mag   (r_mag),
        .i_den   (r_prod),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    // squared side lengths from registered deltas, and twice-area magnitude
    logic [D2_W-1:0]    d2_ab, d2_bc, d2_ac;
    logic [CROSS_W-1:0] cross_abs;
    logic               degen;

    assign d2_ab = D2_W'(r_dx1 * r_dx1 + r_dy1 * r_dy1);
    assign d2_bc = D2_W'(r_dx2 * r_dx2 + r_dy2 * r_dy2);
    assign d2_ac = D2_W'(r_dx3 * r_dx3 + r_dy3 * r_dy3);
    assign degen = (d2_ab == '0) || (d2_bc == '0) || (d2_ac == '0);
    assign cross_abs = r_cross[CROSS_W-1] ? CROSS_W'(-r_cross) : CROSS_W'(r_cross);

    // saturate the quotient to Q2.16
    logic [CURV_W-1:0] curv_fin;

    always_comb begin
        if (r_neg) begin
            if (div_ovf || (div_quot > QUOT_W'(131072))) begin
                curv_fin = CURV_MIN;
            end else begin
                curv_fin = CURV_W'(-div_quot);
            end
        end else begin
            if (div_ovf || (div_quot > QUOT_W'(CURV_MAX))) begin
                curv_fin = CURV_MAX;
            end else begin
                curv_fin = CURV_W'(div_quot);
            end
        end
    end

    logic out_free;
    assign out_free = !r_res_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sq_start  <= 1'b0;
            r_div_start <= 1'b0;
            r_res_valid <= 1'b0;
            r_side      <= 2'd0;
        end else begin
            r_sq_start  <= 1'b0;
            r_div_start <= 1'b0;
            if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in.mode == MODE_QUERY)) begin
                        r_ia <= ADDR_W'(i_in.index);
                        r_ib <= ADDR_W'(q_mid);
                        r_ic <= ADDR_W'(q_last);
                        if (q_oor) begin
                            r_pend_curv <= '0;
                            r_pend_oor  <= 1'b1;
                            r_state     <= ST_OUT;
                        end else begin
                            r_pend_oor <= 1'b0;
                            r_state    <= ST_RD_A;
                        end
                    end
                end
                ST_RD_A: r_state <= ST_RD_B;
                ST_RD_B: begin
                    {r_ya, r_xa} <= ram_rdata;
                    r_state      <= ST_RD_C;
                end
                ST_RD_C: begin
                    {r_yb, r_xb} <= ram_rdata;
                    r_state      <= ST_LD_C;
                end
                ST_LD_C: begin
                    {r_yc, r_xc} <= ram_rdata;
                    r_state      <= ST_CROSS;
                end
                ST_CROSS: begin
                    r_dx1   <= DELTA_W'(r_xb) - DELTA_W'(r_xa);
                    r_dy1   <= DELTA_W'(r_yb) - DELTA_W'(r_ya);
                    r_dx2   <= DELTA_W'(r_xc) - DELTA_W'(r_xb);
                    r_dy2   <= DELTA_W'(r_yc) - DELTA_W'(r_yb);
                    r_dx3   <= DELTA_W'(r_xc) - DELTA_W'(r_xa);
                    r_dy3   <= DELTA_W'(r_yc) - DELTA_W'(r_ya);
                    r_state <= ST_DIST;
                end
                ST_DIST: begin
                    // area sign and magnitude; halving after abs truncates toward zero
                    r_cross <= r_dx1 * r_dy3 - r_dx3 * r_dy1;
                    r_d2[0] <= d2_ab;
                    r_d2[1] <= d2_bc;
                    r_d2[2] <= d2_ac;
                    r_side  <= 2'd0;
                    if (degen) begin
                        r_pend_curv <= '0;
                        r_state     <= ST_OUT;
                    end else begin
                        r_sq_start <= 1'b1;
                        r_state    <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_neg <= r_cross[CROSS_W-1];
                    r_mag <= cross_abs[MAG_W:1];
                    if (sq_done) begin
                        r_root[r_side] <= sq_root;
                        if (r_side == 2'd2) begin
                            r_state <= ST_MUL1;
                        end else begin
                            r_side     <= r_side + 2'd1;
                            r_sq_start <= 1'b1;
                        end
                    end
                end
                ST_MUL1: begin
                    r_p1    <= r_root[0] * r_root[1];
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_prod      <= PROD_W'(r_p1 * r_root[2]);
                    r_div_start <= 1'b1;
                    r_state     <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_pend_curv <= curv_fin;
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_res_valid <= 1'b1;
                        r_res_curv  <= r_pend_curv;
                        r_res_oor   <= r_pend_oor;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.curvature    = r_res_curv;
    assign o_res.out_of_range = r_res_oor;

`ifndef SYNTHESIS
    a_sqrt_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == ST_SQRT))
        else $error("root unit finished outside the root phase");
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_oor) |-> (r_res_curv == '0))
        else $error("out-of-range result carries non-zero curvature");
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.mode == MODE_QUERY)) |=>
            ((r_state == ST_RD_A) || (r_state == ST_OUT)))
        else $error("query did not start a read or a result");
`endif
endmodule
